FILE: sv/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants of the cartridge bank controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cbc_pkg;

  // Field widths of the bus access and of the result.
  localparam int unsigned AddrW     = 16;
  localparam int unsigned DataW     = 8;
  localparam int unsigned MemAddrW  = 23;
  localparam int unsigned TargetW   = 2;

  // Configuration register widths.
  localparam int unsigned KindW     = 3;
  localparam int unsigned RomCountW = 10;
  localparam int unsigned RamCountW = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 10;

  // Bank numbers are limited to the largest supported ROM and RAM.
  localparam int unsigned MaxRomBanks = 512;
  localparam int unsigned MaxRamBanks = 16;
  localparam int unsigned RomBankW    = $clog2(MaxRomBanks);
  localparam int unsigned RamBankW    = $clog2(MaxRamBanks);

  // Internal nibble RAM of the type 2 controller.
  localparam int unsigned NibDepth = 512;
  localparam int unsigned NibAddrW = $clog2(NibDepth);

  localparam logic [DataW-1:0]     OpenBusByte     = 8'hFF;
  localparam logic [3:0]           RamEnableKey    = 4'hA;
  localparam logic [RomCountW-1:0] Type1LargeBanks = 10'd64;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MAPPER_KIND = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROM_BANKS   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RAM_BANKS   = 2'd2;

  typedef enum logic [KindW-1:0] {
    KIND_NONE  = 3'd0,
    KIND_TYPE1 = 3'd1,
    KIND_TYPE2 = 3'd2,
    KIND_TYPE3 = 3'd3,
    KIND_TYPE5 = 3'd4
  } kind_e;

  typedef enum logic [TargetW-1:0] {
    TGT_OPEN     = 2'd0,
    TGT_ROM      = 2'd1,
    TGT_CART_RAM = 2'd2,
    TGT_NIB_RAM  = 2'd3
  } target_e;

  // Configuration as seen by the bank mapping.
  typedef struct packed {
    logic [KindW-1:0]     mapper_kind;
    logic [RomCountW-1:0] rom_bank_count;
    logic [RamCountW-1:0] ram_bank_count;
  } cfg_t;

  // Bank registers written through the ROM range.
  typedef struct packed {
    logic       ram_enable;
    logic [7:0] rom_bank_low;
    logic [1:0] rom_bank_high;
    logic [3:0] ram_bank_select;
    logic       banking_mode;
  } bank_regs_t;

  // Banks currently mapped into the two ROM windows and the RAM window.
  typedef struct packed {
    logic [RomBankW-1:0] rom_lower;
    logic [RomBankW-1:0] rom_upper;
    logic [RamBankW-1:0] ram_bank;
  } banks_t;

endpackage

`default_nettype wire

FILE: sv/cbc_bank_map.sv
// ----------------------------------------------------------------------------
// cbc_bank_map
// Derives the mapped ROM and RAM banks from the bank registers and the
// configured controller kind and bank counts.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_bank_map
  import cbc_pkg::*;
(
  input  wire cfg_t       cfg_i,
  input  wire bank_regs_t regs_i,
  output banks_t          banks_o
);

  logic [RomCountW-1:0] rom_count_m1;
  logic [RamCountW-1:0] ram_count_m1;
  logic [RomBankW-1:0]  rom_mask;
  logic [RamBankW-1:0]  ram_mask;
  logic                 large_rom;
  logic [6:0]           t1_upper;
  logic [6:0]           t1_lower;
  logic [1:0]           t1_ram;
  logic [3:0]           t2_upper;
  logic [6:0]           t3_upper;

  assign rom_count_m1 = cfg_i.rom_bank_count - 1'b1;
  assign ram_count_m1 = cfg_i.ram_bank_count - 1'b1;
  assign rom_mask     = rom_count_m1[RomBankW-1:0];
  assign ram_mask     = ram_count_m1[RamBankW-1:0];
  assign large_rom    = cfg_i.rom_bank_count >= Type1LargeBanks;

  always_comb begin
    // Type 1: the two high bits extend the ROM bank on large ROMs, else in
    // mode 1 they select the RAM bank. A zero low part skips to the next bank.
    t1_upper = large_rom ? {regs_i.rom_bank_high, regs_i.rom_bank_low[4:0]}
                         : {2'b00, regs_i.rom_bank_low[4:0]};
    if (regs_i.rom_bank_low[4:0] == 5'd0) begin
      t1_upper[0] = 1'b1;
    end
    t1_lower = (large_rom && regs_i.banking_mode) ? {regs_i.rom_bank_high, 5'd0} : 7'd0;
    t1_ram   = (!large_rom && regs_i.banking_mode) ? regs_i.rom_bank_high : 2'd0;

    t2_upper = (regs_i.rom_bank_low[3:0] == 4'd0) ? 4'd1 : regs_i.rom_bank_low[3:0];
    t3_upper = (regs_i.rom_bank_low[6:0] == 7'd0) ? 7'd1 : regs_i.rom_bank_low[6:0];
  end

  always_comb begin
    banks_o.rom_lower = '0;
    banks_o.rom_upper = RomBankW'(1);
    banks_o.ram_bank  = '0;
    unique case (cfg_i.mapper_kind)
      KIND_TYPE1: begin
        banks_o.rom_lower = RomBankW'(t1_lower) & rom_mask;
        banks_o.rom_upper = RomBankW'(t1_upper) & rom_mask;
        banks_o.ram_bank  = RamBankW'(t1_ram) & ram_mask;
      end
      KIND_TYPE2: begin
        banks_o.rom_upper = RomBankW'(t2_upper) & rom_mask;
      end
      KIND_TYPE3: begin
        banks_o.rom_upper = RomBankW'(t3_upper) & rom_mask;
        banks_o.ram_bank  = RamBankW'(regs_i.ram_bank_select[1:0]) & ram_mask;
      end
      KIND_TYPE5: begin
        banks_o.rom_upper = RomBankW'({regs_i.rom_bank_high[0], regs_i.rom_bank_low})
                            & rom_mask;
        banks_o.ram_bank  = RamBankW'(regs_i.ram_bank_select) & ram_mask;
      end
      default: begin
        // No banking: fixed lower and upper banks, RAM bank zero.
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/cartridge_bank_controller.sv
// ----------------------------------------------------------------------------
// cartridge_bank_controller
// Translates cartridge bus accesses into ROM, cartridge RAM or nibble RAM
// requests and keeps the bank registers of the selected controller kind.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the slave stream is one bus access: tuser carries the
// read/write flag, tdata the address and the write byte. Each request gives
// exactly one result on the master stream: tuser carries the target and
// tdata the translated address, the write strobe and byte and the read byte.
// A result appears in the cycle after its request is accepted, and unless the
// receiver stalls, the throughput is one access per cycle.
// Bank register writes take effect on the very next access.
// The result register holds its contents while the receiver stalls; the next
// request is taken in the same cycle in which the held result is taken.
// After reset the 512-entry nibble RAM is cleared one entry per cycle, and
// the slave side stays not ready until the clearing is done. Configuration
// writes are taken at any time, including during that clearing pass.
// Reset sets the controller to no banking with two ROM banks and no RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_controller
  import cbc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  // Configuration write port.
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,

  // Bus access requests.
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [23:0]         s_axis_tdata,   // address[15:0], write_data[23:16]
  input  wire logic                s_axis_tuser,   // operation[0]

  // Access results.
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [39:0]         m_axis_tdata,   // memory_address[22:0],
                                                   // memory_write[23],
                                                   // memory_write_data[31:24],
                                                   // read_data[39:32]
  output      logic [TargetW-1:0]  m_axis_tuser    // target[1:0]
);

  // Configuration registers.
  cfg_t       cfg_q;

  // Bank registers and the mapping derived from them.
  bank_regs_t regs_q, regs_d;
  banks_t     banks;

  // Request fields.
  logic              op_write;
  logic [AddrW-1:0]  addr;
  logic [DataW-1:0]  wdata;
  logic              accept;

  // Access decode.
  logic              in_rom_range;
  logic              in_ram_range;
  logic              kind_known;
  logic              enable_key;
  logic [NibAddrW-1:0] nib_idx;
  logic              nib_write;

  // Result computed for the request being accepted.
  target_e             res_target;
  logic [MemAddrW-1:0] res_addr;
  logic                res_mw;
  logic [DataW-1:0]    res_mwd;
  logic [DataW-1:0]    res_rd;
  logic                res_nib_read;

  // Result register.
  logic                out_valid_q;
  target_e             out_target_q;
  logic [MemAddrW-1:0] out_addr_q;
  logic                out_mw_q;
  logic [DataW-1:0]    out_mwd_q;
  logic [DataW-1:0]    out_rd_q;
  logic                out_nib_q;

  // Nibble RAM and its clearing pass.
  logic [3:0]          nib_mem [NibDepth];
  logic [3:0]          nib_rd_q;
  logic                clr_busy_q;
  logic [NibAddrW-1:0] clr_cnt_q;
  logic                mem_we;
  logic [NibAddrW-1:0] mem_waddr;
  logic [3:0]          mem_wdata;

  assign op_write = s_axis_tuser;
  assign addr     = s_axis_tdata[15:0];
  assign wdata    = s_axis_tdata[23:16];

  // The result register is free when empty or when its result leaves now.
  assign s_axis_tready = !clr_busy_q && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mapper_kind    <= KIND_NONE;
      cfg_q.rom_bank_count <= RomCountW'(2);
      cfg_q.ram_bank_count <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAPPER_KIND: cfg_q.mapper_kind    <= cfg_data_i[KindW-1:0];
        CFG_ROM_BANKS:   cfg_q.rom_bank_count <= cfg_data_i[RomCountW-1:0];
        CFG_RAM_BANKS:   cfg_q.ram_bank_count <= cfg_data_i[RamCountW-1:0];
        default: begin
          // Indexes beyond the register list are ignored.
        end
      endcase
    end
  end

  cbc_bank_map u_bank_map (
    .cfg_i   (cfg_q),
    .regs_i  (regs_q),
    .banks_o (banks)
  );

  // --------------------------------------------------------------------------
  // Access decode
  // --------------------------------------------------------------------------
  assign in_rom_range = !addr[15];
  assign in_ram_range = (addr[15:13] == 3'b101);
  assign kind_known   = (cfg_q.mapper_kind == KIND_TYPE1) ||
                        (cfg_q.mapper_kind == KIND_TYPE2) ||
                        (cfg_q.mapper_kind == KIND_TYPE3) ||
                        (cfg_q.mapper_kind == KIND_TYPE5);
  assign enable_key   = (wdata[3:0] == RamEnableKey);
  assign nib_idx      = addr[NibAddrW-1:0];

  // Writes into the ROM range program the bank registers of the current kind.
  always_comb begin
    regs_d = regs_q;
    if (accept && op_write && in_rom_range) begin
      unique case (cfg_q.mapper_kind)
        KIND_TYPE1: begin
          unique case (addr[14:13])
            2'd0: regs_d.ram_enable    = enable_key;
            2'd1: regs_d.rom_bank_low  = wdata;
            2'd2: regs_d.rom_bank_high = wdata[1:0];
            2'd3: regs_d.banking_mode  = wdata[0];
            default: ;
          endcase
        end
        KIND_TYPE2: begin
          if (!addr[14]) begin
            if (addr[8]) begin
              regs_d.rom_bank_low = wdata;
            end else begin
              regs_d.ram_enable = enable_key;
            end
          end
        end
        KIND_TYPE3: begin
          unique case (addr[14:13])
            2'd0: regs_d.ram_enable      = enable_key;
            2'd1: regs_d.rom_bank_low    = wdata;
            2'd2: regs_d.ram_bank_select = {2'b00, wdata[1:0]};
            default: ;
          endcase
        end
        KIND_TYPE5: begin
          unique case (addr[14:12])
            3'd0, 3'd1: regs_d.ram_enable      = enable_key;
            3'd2:       regs_d.rom_bank_low    = wdata;
            3'd3:       regs_d.rom_bank_high   = wdata[1:0];
            3'd4, 3'd5: regs_d.ram_bank_select = wdata[3:0];
            default: ;
          endcase
        end
        default: begin
          // No banking: control writes have no effect.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.ram_enable      <= 1'b0;
      regs_q.rom_bank_low    <= 8'd1;
      regs_q.rom_bank_high   <= 2'd0;
      regs_q.ram_bank_select <= 4'd0;
      regs_q.banking_mode    <= 1'b0;
    end else begin
      regs_q <= regs_d;
    end
  end

  // Result of the access, taken from the bank state before its own update.
  always_comb begin
    res_target   = TGT_OPEN;
    res_addr     = '0;
    res_mw       = 1'b0;
    res_mwd      = '0;
    res_nib_read = 1'b0;
    nib_write    = 1'b0;
    if (in_rom_range) begin
      if (!op_write) begin
        res_target = TGT_ROM;
        res_addr   = {(addr[14] ? banks.rom_upper : banks.rom_lower), addr[13:0]};
      end
    end else if (in_ram_range) begin
      if (cfg_q.mapper_kind == KIND_TYPE2) begin
        if (regs_q.ram_enable) begin
          res_target   = TGT_NIB_RAM;
          res_addr     = MemAddrW'(nib_idx);
          nib_write    = op_write;
          res_nib_read = !op_write;
        end
      end else if ((cfg_q.ram_bank_count != '0) && (regs_q.ram_enable || !kind_known)) begin
        res_target = TGT_CART_RAM;
        res_addr   = MemAddrW'({banks.ram_bank, addr[12:0]});
        res_mw     = op_write;
        res_mwd    = op_write ? wdata : '0;
      end
    end
    res_rd = (res_target == TGT_OPEN) ? OpenBusByte : '0;
  end

  // --------------------------------------------------------------------------
  // Nibble RAM: one write port shared with the clearing pass, one read port
  // whose data is registered at acceptance.
  // --------------------------------------------------------------------------
  assign mem_we    = clr_busy_q || (accept && nib_write);
  assign mem_waddr = clr_busy_q ? clr_cnt_q : nib_idx;
  assign mem_wdata = clr_busy_q ? 4'h0 : wdata[3:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      nib_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      nib_rd_q <= nib_mem[nib_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == NibAddrW'(NibDepth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_target_q <= res_target;
      out_addr_q   <= res_addr;
      out_mw_q     <= res_mw;
      out_mwd_q    <= res_mwd;
      out_rd_q     <= res_rd;
      out_nib_q    <= res_nib_read;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_target_q;
  assign m_axis_tdata  = {(out_nib_q ? {4'hF, nib_rd_q} : out_rd_q),
                          out_mwd_q, out_mw_q, out_addr_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A cartridge RAM write strobe only comes with a cartridge RAM target.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_mw_q) |-> (out_target_q == TGT_CART_RAM))
    else $error("write strobe without cartridge RAM target");

  // Open bus always reads as all ones.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_target_q == TGT_OPEN)) |-> (m_axis_tdata[39:32] == OpenBusByte))
    else $error("open bus result does not read as all ones");

  // A new result only follows a request that was taken outside the clearing
  // pass of the nibble RAM.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(accept && !clr_busy_q))
    else $error("result produced without an accepted request");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the cartridge bank controller. Bus access requests
// are streamed in under several controller settings while both stream sides
// stall at random. A behavioral copy of the bank logic, its registers and
// the nibble RAM predicts every result, and each result is compared field by
// field in order of arrival.
// ----------------------------------------------------------------------------

module tb_top;
  import cbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The read/write flag travels in tuser of the request stream.
  localparam bit OP_READ  = 1'b0;
  localparam bit OP_WRITE = 1'b1;

  localparam int unsigned PHASES         = 16;
  localparam int unsigned ITEMS_PER_PASS = 108;
  localparam int unsigned REPORT_LIMIT   = 10;

  // One predicted result, in the field order of the result stream.
  typedef struct packed {
    target_e             target;
    logic [MemAddrW-1:0] mem_addr;
    logic                mem_write;
    logic [DataW-1:0]    mem_wdata;
    logic [DataW-1:0]    read_byte;
  } access_result_t;

  // Mirror of the bank controller. The bank registers and the nibble RAM are
  // updated as requests are accepted and the configuration as it is written,
  // so each predicted result is based on exactly the state the hardware sees.
  class bank_scoreboard;
    logic [KindW-1:0]     kind;
    logic [RomCountW-1:0] rom_count;
    logic [RamCountW-1:0] ram_count;
    bank_regs_t           regs;
    logic [3:0]           nibbles [NibDepth];
    access_result_t       results_due [$];
    int unsigned          errors;

    function new();
      kind = KIND_NONE;
      rom_count = 2;
      ram_count = 0;
      regs = '{ram_enable: 1'b0, rom_bank_low: 8'd1, rom_bank_high: 2'd0,
               ram_bank_select: 4'd0, banking_mode: 1'b0};
      foreach (nibbles[i]) nibbles[i] = 4'h0;
      errors = 0;
    endfunction

    function void write_config(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_MAPPER_KIND: kind = value[KindW-1:0];
        CFG_ROM_BANKS:   rom_count = value[RomCountW-1:0];
        CFG_RAM_BANKS:   ram_count = value[RamCountW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction

    // Banks seen through the lower ROM window, the upper ROM window and the
    // RAM window for the current kind and register contents.
    function void mapped_banks(output int unsigned lower, output int unsigned upper,
                               output int unsigned ram_bank);
      int unsigned rom_mask;
      int unsigned ram_mask;
      // A zero or odd count still acts as a plain mask limited to the bank width.
      rom_mask = (32'(rom_count) - 1) & (MaxRomBanks - 1);
      ram_mask = (32'(ram_count) - 1) & (MaxRamBanks - 1);
      lower = 0;
      upper = 1;
      ram_bank = 0;
      case (kind)
        KIND_TYPE1: begin
          if (rom_count >= Type1LargeBanks) begin
            // Large ROM: the high register selects the 512 KiB block.
            lower = regs.banking_mode ? (32'(regs.rom_bank_high) << 5) : 0;
            upper = (32'(regs.rom_bank_high) << 5) | (32'(regs.rom_bank_low) & 31);
          end else begin
            ram_bank = regs.banking_mode ? 32'(regs.rom_bank_high) : 0;
            upper = 32'(regs.rom_bank_low) & 31;
          end
          if (upper inside {0, 32, 64, 96}) upper = upper + 1;
          lower = lower & rom_mask;
          upper = upper & rom_mask;
          ram_bank = ram_bank & ram_mask;
        end
        KIND_TYPE2: begin
          upper = 32'(regs.rom_bank_low) & 15;
          if (upper == 0) upper = 1;
          upper = upper & rom_mask;
        end
        KIND_TYPE3: begin
          upper = 32'(regs.rom_bank_low) & 127;
          if (upper == 0) upper = 1;
          upper = upper & rom_mask;
          ram_bank = (32'(regs.ram_bank_select) & 3) & ram_mask;
        end
        KIND_TYPE5: begin
          upper = ((32'(regs.rom_bank_high) & 1) << 8 | 32'(regs.rom_bank_low)) & rom_mask;
          ram_bank = 32'(regs.ram_bank_select) & ram_mask;
        end
        default: ;
      endcase
    endfunction

    // A write into the ROM range programs the bank registers of the kind.
    function void apply_control(logic [AddrW-1:0] addr, logic [DataW-1:0] value);
      logic enable_key;
      enable_key = (value[3:0] == RamEnableKey);
      case (kind)
        KIND_TYPE1: begin
          if (addr < 16'h2000) regs.ram_enable = enable_key;
          else if (addr < 16'h4000) regs.rom_bank_low = value;
          else if (addr < 16'h6000) regs.rom_bank_high = value[1:0];
          else regs.banking_mode = value[0];
        end
        KIND_TYPE2: begin
          if (addr < 16'h4000) begin
            if (addr[8]) regs.rom_bank_low = value;
            else regs.ram_enable = enable_key;
          end
        end
        KIND_TYPE3: begin
          if (addr < 16'h2000) regs.ram_enable = enable_key;
          else if (addr < 16'h4000) regs.rom_bank_low = value;
          else if (addr < 16'h6000) regs.ram_bank_select = {2'b00, value[1:0]};
        end
        KIND_TYPE5: begin
          if (addr < 16'h2000) regs.ram_enable = enable_key;
          else if (addr < 16'h3000) regs.rom_bank_low = value;
          else if (addr < 16'h4000) regs.rom_bank_high = value[1:0];
          else if (addr < 16'h6000) regs.ram_bank_select = value[3:0];
        end
        default: ;
      endcase
    endfunction

    function void note_access(bit op, logic [AddrW-1:0] addr, logic [DataW-1:0] wdata);
      access_result_t r;
      int unsigned lower, upper, ram_bank;
      logic [12:0] offset;
      logic [NibAddrW-1:0] idx;
      bit known;
      known = (kind >= KIND_TYPE1) && (kind <= KIND_TYPE5);
      // Banks are taken before a control write so that it only affects later requests.
      mapped_banks(lower, upper, ram_bank);
      r = '0;
      r.target = TGT_OPEN;
      if (addr < 16'h8000) begin
        if (op == OP_WRITE) begin
          apply_control(addr, wdata);
        end else begin
          r.target = TGT_ROM;
          r.mem_addr = MemAddrW'((((addr < 16'h4000) ? lower : upper) << 14)
                                 | 32'(addr[13:0]));
        end
      end else if (addr >= 16'hA000 && addr < 16'hC000) begin
        offset = 13'(addr - 16'hA000);
        if (kind == KIND_TYPE2) begin
          // The nibble RAM ignores the RAM bank count.
          if (regs.ram_enable) begin
            idx = offset[NibAddrW-1:0];
            r.target = TGT_NIB_RAM;
            r.mem_addr = MemAddrW'(idx);
            if (op == OP_WRITE) nibbles[idx] = wdata[3:0];
            else r.read_byte = {4'hF, nibbles[idx]};
          end
        end else if (ram_count != 0 && (regs.ram_enable || !known)) begin
          r.target = TGT_CART_RAM;
          r.mem_addr = MemAddrW'((ram_bank << 13) | 32'(offset));
          if (op == OP_WRITE) begin
            r.mem_write = 1'b1;
            r.mem_wdata = wdata;
          end
        end
      end
      if (r.target == TGT_OPEN) r.read_byte = OpenBusByte;
      results_due.push_back(r);
    endfunction

    function void check_result(logic [TargetW-1:0] user, logic [39:0] data);
      access_result_t got, want;
      got.target    = target_e'(user);
      got.mem_addr  = data[22:0];
      got.mem_write = data[23];
      got.mem_wdata = data[31:24];
      got.read_byte = data[39:32];
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result with no request outstanding: target %0d address %h",
                   $time, got.target, got.mem_addr);
        return;
      end
      want = results_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("%0t: result mismatch (expected/actual): target %0d/%0d address %h/%h",
                   $time, want.target, got.target, want.mem_addr, got.mem_addr);
          $display("%0t:   write %b/%b wdata %h/%h rdata %h/%h", $time,
                   want.mem_write, got.mem_write, want.mem_wdata, got.mem_wdata,
                   want.read_byte, got.read_byte);
        end
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;   // address[15:0], write_data[23:16]
  logic                s_axis_tuser;   // operation[0]
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [39:0]         m_axis_tdata;   // memory_address[22:0], memory_write[23],
                                       // memory_write_data[31:24], read_data[39:32]
  logic [TargetW-1:0]  m_axis_tuser;   // target[1:0]

  // Set for the closing phases: no receiver stalls and no random sender gaps.
  bit calm = 1'b0;

  bank_scoreboard sb;

  cartridge_bank_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Both streams are observed at the rising edge. A result is checked before
  // the request of the same edge is noted, although a result never belongs
  // to a request accepted at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_access(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16]);
    end
  end

  // The receiver alternates ready bursts with stall bursts until the closing
  // phases. Ready bursts without a following stall give stretches of full rate.
  initial begin
    int unsigned burst;
    m_axis_tready = 1'b0;
    forever begin
      if (calm) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b1;
        end
        if ($urandom_range(0, 2) == 0) begin
          burst = $urandom_range(1, 12);
          repeat (burst) begin
            @(negedge clk_i);
            m_axis_tready <= 1'b0;
          end
        end
      end
    end
  end

  // Presents one request and returns after the edge that accepts it. Valid is
  // left high so that back-to-back requests keep it high without a glitch.
  task automatic send_access(bit op, logic [AddrW-1:0] addr, logic [DataW-1:0] wdata);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {wdata, addr};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_sender(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // Stops sending and waits until every outstanding request has its result.
  task automatic drain();
    idle_sender(1);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    sb.write_config(idx, value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Settings change only while the controller is idle. Every request yields
  // a result, so nothing is left in flight once the last result is in.
  task automatic configure(int unsigned kind, int unsigned roms, int unsigned rams);
    drain();
    write_register(CFG_MAPPER_KIND, CfgDataW'(kind));
    write_register(CFG_ROM_BANKS, CfgDataW'(roms));
    write_register(CFG_RAM_BANKS, CfgDataW'(rams));
  endtask

  initial begin
    int unsigned kind, roms, rams, gap_pct, pick;
    bit op;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;

    sb = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_MAPPER_KIND;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_READ;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Reset state first: plain 32 KiB ROM without RAM, where
    // control writes are ignored and the RAM range is open bus.
    send_access(OP_READ,  16'h0000, 8'h00);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    send_access(OP_WRITE, 16'h2000, 8'h05);
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_READ,  16'hA000, 8'h00);
    send_access(OP_WRITE, 16'hFFFF, 8'hFF);
    send_access(OP_READ,  16'h8000, 8'h00);
    send_access(OP_WRITE, 16'h9FFF, 8'h00);

    // Type 1 with a large ROM: bank zero is remapped, the high bits select
    // the block in both windows in mode 1.
    configure(KIND_TYPE1, 64, 4);
    send_access(OP_WRITE, 16'h0000, 8'h0A);
    send_access(OP_WRITE, 16'h2000, 8'h00);
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_WRITE, 16'h4000, 8'h03);
    send_access(OP_WRITE, 16'h6000, 8'h01);
    send_access(OP_READ,  16'h0000, 8'h00);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    send_access(OP_WRITE, 16'hBFFF, 8'hFF);

    // Type 2: the nibble RAM keeps the low nibble and aliases every 512 bytes.
    configure(KIND_TYPE2, 16, 0);
    send_access(OP_WRITE, 16'h01FF, 8'h0F);
    send_access(OP_WRITE, 16'h0000, 8'h0A);
    send_access(OP_WRITE, 16'hA1FF, 8'hFF);
    send_access(OP_READ,  16'hA1FF, 8'h00);
    send_access(OP_READ,  16'hBFFF, 8'h00);
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_WRITE, 16'h0000, 8'h00);
    send_access(OP_READ,  16'hA000, 8'h00);

    // Random part. The first settings cover every defined kind and two undefined
    // ones, the smallest and largest bank counts and counts that are zero
    // or not a power of two; the later ones are drawn at random.
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0:  begin kind = KIND_TYPE1; roms = 64;   rams = 4;  end
        1:  begin kind = KIND_TYPE1; roms = 32;   rams = 4;  end
        2:  begin kind = KIND_TYPE1; roms = 512;  rams = 16; end
        3:  begin kind = KIND_TYPE2; roms = 16;   rams = 0;  end
        4:  begin kind = KIND_TYPE3; roms = 128;  rams = 4;  end
        5:  begin kind = KIND_TYPE5; roms = 512;  rams = 16; end
        6:  begin kind = KIND_NONE;  roms = 2;    rams = 1;  end
        7:  begin kind = KIND_TYPE1; roms = 2;    rams = 0;  end
        8:  begin kind = KIND_TYPE5; roms = 2;    rams = 1;  end
        9:  begin kind = KIND_TYPE3; roms = 0;    rams = 3;  end
        10: begin kind = 6;          roms = 1023; rams = 31; end
        11: begin kind = KIND_TYPE2; roms = 512;  rams = 16; end
        12: begin kind = 5;          roms = 8;    rams = 2;  end
        default: begin
          kind = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 7);
          roms = 1 << $urandom_range(1, 9);
          rams = ($urandom_range(0, 5) == 0) ? 0 : (1 << $urandom_range(0, 4));
        end
      endcase
      // Changing settings waits for every outstanding result first.
      configure(kind, roms, rams);
      calm = (p >= PHASES - 2);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 35;
      endcase
      if (calm) gap_pct = 0;

      for (int unsigned n = 0; n < ITEMS_PER_PASS; n++) begin
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
          idle_sender($urandom_range(1, 12));
        pick  = $urandom_range(0, 99);
        op    = OP_READ;
        wdata = 8'($urandom);
        if (pick < 30) begin
          // Control write; enable keys and type 1 remap values are favored.
          op = OP_WRITE;
          addr = 16'($urandom_range(0, 3) << 13) | 16'($urandom_range(0, 16'h1FFF));
          if ($urandom_range(0, 1) == 0) wdata[3:0] = RamEnableKey;
          else if ($urandom_range(0, 3) == 0) wdata = wdata & 8'hE0;
        end else if (pick < 55) begin
          addr = 16'($urandom_range(0, 16'h7FFF));
        end else if (pick < 90) begin
          op = bit'($urandom_range(0, 1));
          addr = 16'hA000 | 16'($urandom_range(0, 16'h1FFF));
          // Reuse a few nibble entries so that writes are read back.
          if (sb.kind == KIND_TYPE2 && $urandom_range(0, 1) == 0)
            addr = 16'hA000 | (addr & 16'h1E00) | 16'($urandom_range(0, 7));
        end else begin
          op = bit'($urandom_range(0, 1));
          addr = 16'($urandom);
        end
        send_access(op, addr, wdata);
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
